/* rtl/core/bounded_ordered_list_top_assert.svh */
// assertion macros for the bounded ordered list checker
`ifndef BOUNDED_ORDERED_LIST_TOP_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_TOP_ASSERT_SVH

// same-cycle implication
`define BOL_ASSERT_SAME(label, cond, expect_cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (expect_cond)) \
        else $error("bounded_ordered_list check failed");

// next-cycle implication
`define BOL_ASSERT_NEXT(label, cond, expect_cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_cond)) \
        else $error("bounded_ordered_list check failed");

`endif

/* rtl/core/bol_pkg.sv */
// shared types and constants for the bounded ordered list
package bol_pkg;

    localparam int CAPACITY   = 16;
    localparam int ENTRY_BITS = 16;
    localparam int POS_BITS   = 4;
    localparam int COUNT_BITS = 5;

    typedef enum logic [2:0] {
        ACT_APPEND,
        ACT_GET,
        ACT_INDEX_OF,
        ACT_INSERT_AT,
        ACT_REMOVE_AT,
        ACT_REMOVE_LAST,
        ACT_SET,
        ACT_SIZE
    } action_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_FULL,
        ST_BADPOS,
        ST_NOTFOUND,
        ST_ZERO
    } status_t;

    typedef struct packed {
        action_t               action;
        logic [POS_BITS-1:0]   position;
        logic [ENTRY_BITS-1:0] entry;
    } cmd_item_t;

    typedef struct packed {
        status_t               status;
        logic [ENTRY_BITS-1:0] entry_out;
        logic [POS_BITS-1:0]   index_out;
        logic [COUNT_BITS-1:0] count_out;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GET,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_POS,
        RD_PTR,
        RD_NEIGHBOR
    } rd_src_t;

    typedef enum logic [1:0] {
        WR_APPEND,
        WR_POS,
        WR_SHIFT
    } wr_src_t;

    typedef enum logic [1:0] {
        PTR_ZERO,
        PTR_COUNT,
        PTR_POS
    } ptr_src_t;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        rd_src_t  rd_src;
        logic     wr_en;
        wr_src_t  wr_src;
        logic     ptr_load;
        ptr_src_t ptr_src;
        logic     ptr_step;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     set_status;
        status_t  status_val;
        logic     take_entry;
        logic     take_index;
        logic     rsp_load;
    } ctl_cmd_t;

    typedef struct packed {
        action_t action;
        status_t check;
        logic    walk_more;
        logic    match;
        logic    rsp_busy;
    } dp_stat_t;

endpackage

/* rtl/core/bol_datapath.sv */
// datapath: slot memory, count, walk pointer, item and result registers
module bol_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bol_pkg::cmd_item_t   cmd,
    input  bol_pkg::ctl_cmd_t    ctl,
    output bol_pkg::dp_stat_t    stat,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output bol_pkg::rsp_item_t   rsp
);
    import bol_pkg::*;

    logic [ENTRY_BITS-1:0] mem [CAPACITY];
    logic [ENTRY_BITS-1:0] rd_data_reg;
    logic [POS_BITS-1:0]   rd_addr;
    logic [POS_BITS-1:0]   wr_addr;
    logic [ENTRY_BITS-1:0] wr_data;

    cmd_item_t             item_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [POS_BITS-1:0]   ptr_reg;
    logic [POS_BITS-1:0]   ptr_next;
    logic [POS_BITS-1:0]   neighbor;
    logic                  is_insert;

    status_t               status_reg;
    logic [ENTRY_BITS-1:0] eout_reg;
    logic [POS_BITS-1:0]   iout_reg;
    rsp_item_t             rsp_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;

    logic                  entry_zero;
    logic                  full;
    logic                  pos_in;
    logic                  pos_le;
    status_t               check;

    assign is_insert  = (item_reg.action == ACT_INSERT_AT);
    assign neighbor   = is_insert ? ptr_reg - POS_BITS'(1) : ptr_reg + POS_BITS'(1);
    assign entry_zero = (item_reg.entry == '0);
    assign full       = (count_reg == COUNT_BITS'(CAPACITY));
    assign pos_in     = (COUNT_BITS'(item_reg.position) < count_reg);
    assign pos_le     = (COUNT_BITS'(item_reg.position) <= count_reg);

    always_comb
    begin
        check = ST_OK;
        unique case (item_reg.action)
            ACT_APPEND:
            begin
                if (entry_zero)
                    check = ST_ZERO;
                else if (full)
                    check = ST_FULL;
            end
            ACT_GET:
            begin
                if (!pos_in)
                    check = ST_BADPOS;
            end
            ACT_INDEX_OF:
            begin
                if (entry_zero)
                    check = ST_ZERO;
                else if (count_reg == '0)
                    check = ST_NOTFOUND;
            end
            ACT_INSERT_AT:
            begin
                if (entry_zero)
                    check = ST_ZERO;
                else if (full)
                    check = ST_FULL;
                else if (!pos_le)
                    check = ST_BADPOS;
            end
            ACT_REMOVE_AT:
            begin
                if (!pos_in)
                    check = ST_BADPOS;
            end
            ACT_REMOVE_LAST:
            begin
                if (count_reg == '0)
                    check = ST_BADPOS;
            end
            ACT_SET:
            begin
                if (entry_zero)
                    check = ST_ZERO;
                else if (!pos_in)
                    check = ST_BADPOS;
            end
            ACT_SIZE:
            begin
                check = ST_OK;
            end
            default:
            begin
                check = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        stat.action    = item_reg.action;
        stat.check     = check;
        stat.match     = (rd_data_reg == item_reg.entry);
        stat.rsp_busy  = rsp_valid_reg && !rsp_ready;
        if (is_insert)
            stat.walk_more = (ptr_reg > item_reg.position);
        else
            stat.walk_more = ((COUNT_BITS'(ptr_reg) + COUNT_BITS'(1)) < count_reg);
    end

    always_comb
    begin
        unique case (ctl.rd_src)
            RD_POS:      rd_addr = item_reg.position;
            RD_PTR:      rd_addr = ptr_reg;
            RD_NEIGHBOR: rd_addr = neighbor;
            default:     rd_addr = ptr_reg;
        endcase
        unique case (ctl.wr_src)
            WR_APPEND:
            begin
                wr_addr = count_reg[POS_BITS-1:0];
                wr_data = item_reg.entry;
            end
            WR_POS:
            begin
                wr_addr = item_reg.position;
                wr_data = item_reg.entry;
            end
            WR_SHIFT:
            begin
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[wr_addr] <= wr_data;
        if (ctl.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (ctl.ptr_load)
        begin
            unique case (ctl.ptr_src)
                PTR_ZERO:  ptr_next = '0;
                PTR_COUNT: ptr_next = count_reg[POS_BITS-1:0];
                PTR_POS:   ptr_next = item_reg.position;
                default:   ptr_next = '0;
            endcase
        end
        else if (ctl.ptr_step)
        begin
            ptr_next = neighbor;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.cnt_inc)
            count_next = count_reg + COUNT_BITS'(1);
        else if (ctl.cnt_dec)
            count_next = count_reg - COUNT_BITS'(1);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (ctl.load)
        begin
            item_reg <= cmd;
            eout_reg <= '0;
            iout_reg <= '0;
        end
        if (ctl.set_status)
            status_reg <= ctl.status_val;
        if (ctl.take_entry)
            eout_reg <= rd_data_reg;
        if (ctl.take_index)
            iout_reg <= ptr_reg;
        if (ctl.rsp_load)
        begin
            rsp_reg.status    <= status_reg;
            rsp_reg.entry_out <= eout_reg;
            rsp_reg.index_out <= iout_reg;
            rsp_reg.count_out <= count_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/core/bol_controller.sv */
// controller: sequences one action over the datapath
module bol_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  bol_pkg::dp_stat_t  stat,
    output bol_pkg::ctl_cmd_t  ctl
);
    import bol_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        ctl.rd_src     = RD_PTR;
        ctl.wr_src     = WR_SHIFT;
        ctl.ptr_src    = PTR_ZERO;
        ctl.status_val = ST_OK;
        cmd_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.set_status = 1'b1;
                ctl.status_val = stat.check;
                state_next     = S_DONE;
                if (stat.check == ST_OK)
                begin
                    unique case (stat.action)
                        ACT_APPEND:
                        begin
                            ctl.wr_en   = 1'b1;
                            ctl.wr_src  = WR_APPEND;
                            ctl.cnt_inc = 1'b1;
                        end
                        ACT_GET:
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_src = RD_POS;
                            state_next = S_GET;
                        end
                        ACT_INDEX_OF:
                        begin
                            ctl.ptr_load = 1'b1;
                            ctl.ptr_src  = PTR_ZERO;
                            state_next   = S_SEARCH_RD;
                        end
                        ACT_INSERT_AT:
                        begin
                            ctl.ptr_load = 1'b1;
                            ctl.ptr_src  = PTR_COUNT;
                            state_next   = S_SHIFT_RD;
                        end
                        ACT_REMOVE_AT:
                        begin
                            ctl.ptr_load = 1'b1;
                            ctl.ptr_src  = PTR_POS;
                            state_next   = S_SHIFT_RD;
                        end
                        ACT_REMOVE_LAST:
                        begin
                            ctl.cnt_dec = 1'b1;
                        end
                        ACT_SET:
                        begin
                            ctl.wr_en  = 1'b1;
                            ctl.wr_src = WR_POS;
                        end
                        ACT_SIZE:
                        begin
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_GET:
            begin
                ctl.take_entry = 1'b1;
                state_next     = S_DONE;
            end
            S_SEARCH_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_src = RD_PTR;
                state_next = S_SEARCH_CMP;
            end
            S_SEARCH_CMP:
            begin
                priority if (stat.match)
                begin
                    ctl.take_index = 1'b1;
                    state_next     = S_DONE;
                end
                else if (stat.walk_more)
                begin
                    ctl.ptr_step = 1'b1;
                    state_next   = S_SEARCH_RD;
                end
                else
                begin
                    ctl.set_status = 1'b1;
                    ctl.status_val = ST_NOTFOUND;
                    state_next     = S_DONE;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.walk_more)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_src = RD_NEIGHBOR;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    if (stat.action == ACT_INSERT_AT)
                    begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_src  = WR_POS;
                        ctl.cnt_inc = 1'b1;
                    end
                    else
                    begin
                        ctl.cnt_dec = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_SHIFT_WR:
            begin
                ctl.wr_en    = 1'b1;
                ctl.wr_src   = WR_SHIFT;
                ctl.ptr_step = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (!stat.rsp_busy)
                begin
                    ctl.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/bounded_ordered_list_top.sv */
// top level of the bounded ordered list
// usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries one action with position and entry
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one result per action:
//   status, entry read by get, index found by index_of and the entry count
// sequence:
//   append, set, remove_last, size and every rejected action: checked and executed
//   in S_EXEC, then the result is loaded in S_DONE; get adds a registered read in S_GET
//   index_of: slots compared from slot 0 up to a match or the last entry, one memory read per compare
//   insert_at / remove_at: entries moved one by one, a read and a write of the
//   slot memory per move, in separate states (S_SHIFT_RD, S_SHIFT_WR)
//   the next action is taken in the cycle after the result is loaded
// reset: entry count cleared, list empty, no result pending; slots are not cleared
// stall: the result register holds while rsp_ready is low; the next action is
// still accepted and worked, and waits only when its own result is ready
module bounded_ordered_list_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  bol_pkg::cmd_item_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output bol_pkg::rsp_item_t rsp
);
    import bol_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    bol_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    bol_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* rtl/core/bol_checker.sv */
// port-level checker for the bounded ordered list, bound to the top level
`include "bounded_ordered_list_top_assert.svh"

module bol_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input bol_pkg::cmd_item_t cmd,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input bol_pkg::rsp_item_t rsp
);
    import bol_pkg::*;

    logic cmd_xfer;
    logic rsp_stall;
    logic rsp_fail;

    assign cmd_xfer  = cmd_valid && cmd_ready;
    assign rsp_stall = rsp_valid && !rsp_ready;
    assign rsp_fail  = rsp_valid && (rsp.status != ST_OK);

    `BOL_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp))
    `BOL_ASSERT_NEXT(a_busy_after_transfer, cmd_xfer, !cmd_ready)
    `BOL_ASSERT_SAME(a_count_bound, rsp_valid, rsp.count_out <= COUNT_BITS'(CAPACITY))
    `BOL_ASSERT_SAME(a_fail_clean, rsp_fail, (rsp.entry_out == '0) && (rsp.index_out == '0))

endmodule

bind bounded_ordered_list_top bol_checker u_bol_checker (.*);

/* test/testbench.sv */
// testbench for the bounded ordered list: random and directed actions checked against a predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bol_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
    localparam int HOLD_OFF = 300;

    class list_scoreboard;
        logic [ENTRY_BITS-1:0] slots [CAPACITY];
        int unsigned entry_count;
        rsp_item_t expected_q [$];
        int errors;

        function new();
            entry_count = 0;
            errors = 0;
        endfunction

        // apply one action to the list copy and return its result
        function rsp_item_t apply_action(cmd_item_t c);
            rsp_item_t r;
            int unsigned p;
            bit found;
            r = '0;
            r.status = ST_OK;
            p = c.position;
            found = 1'b0;
            case (c.action)
                ACT_APPEND:
                    if (c.entry == '0) r.status = ST_ZERO;
                    else if (entry_count >= CAPACITY) r.status = ST_FULL;
                    else
                    begin
                        slots[entry_count] = c.entry;
                        entry_count++;
                    end
                ACT_GET:
                    if (p >= entry_count) r.status = ST_BADPOS;
                    else r.entry_out = slots[p];
                ACT_INDEX_OF:
                    if (c.entry == '0) r.status = ST_ZERO;
                    else
                    begin
                        r.status = ST_NOTFOUND;
                        for (int i = 0; i < entry_count; i++)
                        begin
                            if (!found && slots[i] == c.entry)
                            begin
                                found = 1'b1;
                                r.status = ST_OK;
                                r.index_out = POS_BITS'(i);
                            end
                        end
                    end
                ACT_INSERT_AT:
                    if (c.entry == '0) r.status = ST_ZERO;
                    else if (entry_count >= CAPACITY) r.status = ST_FULL;
                    else if (p > entry_count) r.status = ST_BADPOS;
                    else
                    begin
                        for (int i = entry_count; i > p; i--) slots[i] = slots[i-1];
                        slots[p] = c.entry;
                        entry_count++;
                    end
                ACT_REMOVE_AT:
                    if (p >= entry_count) r.status = ST_BADPOS;
                    else
                    begin
                        for (int i = p; i + 1 < entry_count; i++) slots[i] = slots[i+1];
                        entry_count--;
                    end
                ACT_REMOVE_LAST:
                    if (entry_count == 0) r.status = ST_BADPOS;
                    else entry_count--;
                ACT_SET:
                    if (c.entry == '0) r.status = ST_ZERO;
                    else if (p >= entry_count) r.status = ST_BADPOS;
                    else slots[p] = c.entry;
                default: ;
            endcase
            r.count_out = COUNT_BITS'(entry_count);
            return r;
        endfunction

        task note_transfer(cmd_item_t c);
            expected_q.push_back(apply_action(c));
        endtask

        task report(string what);
            if (errors < 40) $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(rsp_item_t got);
            rsp_item_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result status %0d count %0d",
                                 got.status, got.count_out));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.entry_out !== want.entry_out)
                report($sformatf("entry_out %h, wanted %h", got.entry_out, want.entry_out));
            if (got.index_out !== want.index_out)
                report($sformatf("index_out %0d, wanted %0d", got.index_out, want.index_out));
            if (got.count_out !== want.count_out)
                report($sformatf("count_out %0d, wanted %0d", got.count_out, want.count_out));
        endtask
    endclass

    logic      clk;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    cmd_item_t cmd = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    list_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int cycles = 0;

    bounded_ordered_list_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver side, with a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ready <= 1'b0;
            hold_cycles--;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready) sb.check_result(rsp);

    // offer one action and wait for its transfer
    task automatic send_cmd(cmd_item_t c);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        sb.note_transfer(c);
    endtask

    task automatic send_fields(action_t a, int unsigned p, logic [ENTRY_BITS-1:0] e);
        cmd_item_t c;
        c.action = a;
        c.position = POS_BITS'(p);
        c.entry = e;
        send_cmd(c);
    endtask

    function automatic logic [ENTRY_BITS-1:0] pick_entry(bit prefer_stored);
        int r;
        r = $urandom_range(0, 99);
        if (prefer_stored && sb.entry_count > 0 && r < 60)
            return sb.slots[$urandom_range(0, sb.entry_count - 1)];
        if (r < 5) return '0;
        if (r < 10) return '1;
        if (r < 50) return ENTRY_BITS'($urandom_range(1, 12));
        return ENTRY_BITS'($urandom);
    endfunction

    // mode 0 grows the list, 1 shrinks it, 2 is balanced
    function automatic cmd_item_t make_random_cmd(int mode);
        cmd_item_t c;
        int r;
        int unsigned p;
        r = $urandom_range(0, 99);
        if (mode == 0)
            c.action = r < 30 ? ACT_APPEND : r < 55 ? ACT_INSERT_AT : r < 65 ? ACT_GET :
                       r < 75 ? ACT_INDEX_OF : r < 83 ? ACT_SET : r < 90 ? ACT_REMOVE_AT :
                       r < 95 ? ACT_REMOVE_LAST : ACT_SIZE;
        else if (mode == 1)
            c.action = r < 8 ? ACT_APPEND : r < 15 ? ACT_INSERT_AT : r < 25 ? ACT_GET :
                       r < 35 ? ACT_INDEX_OF : r < 43 ? ACT_SET : r < 70 ? ACT_REMOVE_AT :
                       r < 95 ? ACT_REMOVE_LAST : ACT_SIZE;
        else
            c.action = action_t'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0)
            p = $urandom_range(0, CAPACITY - 1);
        else
            p = $urandom_range(0, sb.entry_count);
        if (p > CAPACITY - 1) p = CAPACITY - 1;
        c.position = POS_BITS'(p);
        c.entry = pick_entry(c.action == ACT_INDEX_OF);
        return c;
    endfunction

    task automatic run_random(int n);
        int mode;
        mode = 0;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0) mode = $urandom_range(0, 2);
            send_cmd(make_random_cmd(mode));
        end
    endtask

    initial
    begin
        send_idle_pct = 24;
        recv_idle_pct = 88;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list and rejection cases
        send_fields(ACT_SIZE, 0, 16'h0000);
        send_fields(ACT_REMOVE_LAST, 0, 16'h0000);
        send_fields(ACT_REMOVE_AT, 0, 16'h0000);
        send_fields(ACT_GET, 0, 16'h0000);
        send_fields(ACT_APPEND, 0, 16'h0000);
        send_fields(ACT_INDEX_OF, 0, 16'h0000);
        send_fields(ACT_INDEX_OF, 0, 16'h0005);
        // build and edit a short list
        send_fields(ACT_APPEND, 15, 16'hFFFF);
        send_fields(ACT_APPEND, 0, 16'h0001);
        send_fields(ACT_INSERT_AT, 2, 16'h8000);
        send_fields(ACT_INSERT_AT, 0, 16'h00AA);
        send_fields(ACT_INSERT_AT, 5, 16'h1234);
        send_fields(ACT_GET, 3, 16'h0000);
        send_fields(ACT_GET, 15, 16'h0000);
        send_fields(ACT_SET, 1, 16'h5555);
        send_fields(ACT_SET, 0, 16'h0000);
        send_fields(ACT_SET, 9, 16'h7777);
        send_fields(ACT_INDEX_OF, 0, 16'h5555);
        send_fields(ACT_APPEND, 0, 16'h00AA);
        send_fields(ACT_INDEX_OF, 7, 16'h00AA);
        send_fields(ACT_REMOVE_AT, 1, 16'h0000);
        send_fields(ACT_REMOVE_AT, 7, 16'h0000);
        send_fields(ACT_REMOVE_LAST, 0, 16'h0000);
        send_fields(ACT_SIZE, 15, 16'hFFFF);

        run_random(400);
        send_idle_pct = 88;
        recv_idle_pct = 24;
        run_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = HOLD_OFF;
        run_random(500);

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bol_pkg.sv
rtl/core/bol_datapath.sv
rtl/core/bol_controller.sv
rtl/core/bounded_ordered_list_top.sv
rtl/core/bol_checker.sv
test/testbench.sv
